### rtl/core/llst_pkg.sv
// Shared types and constants for the least-loaded server table.
// Used by llst_engine and least_loaded_server_table_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package llst_pkg;

  // Table geometry and register reset value
  localparam int unsigned SlotsDefault = 16;
  localparam logic [7:0] MissedLimitReset = 8'd2;

  // Saturation points of the per-slot counters
  localparam logic [15:0] LoadMax = 16'hFFFF;
  localparam logic [7:0] MissedMax = 8'hFF;

  typedef enum logic [2:0] {
    OP_REGISTER   = 3'd0,
    OP_CLIENT     = 3'd1,
    OP_HEARTBEAT  = 3'd2,
    OP_DISCONNECT = 3'd3,
    OP_TICK       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SERVER = 2'd1,
    ST_UNKNOWN   = 2'd2
  } status_e;

  // One request as it enters the engine
  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  slot_id;
    logic [31:0] address;
    logic [15:0] port;
  } req_t;

  // One result as it leaves the engine
  typedef struct packed {
    status_e     status;
    logic [3:0]  slot;
    logic [31:0] address;
    logic [15:0] port;
    logic [15:0] load;
  } res_t;

  // Endpoint memory word and counter memory word
  typedef struct packed {
    logic [31:0] address;
    logic [15:0] port;
  } endpoint_t;

  typedef struct packed {
    logic [15:0] load;
    logic [7:0]  missed;
  } counters_t;

endpackage

`default_nettype wire

### rtl/core/least_loaded_server_table_top.sv
// Top level of the least-loaded server table: configuration register and output stage.
// Instantiates llst_engine; uses llst_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The table holds SLOTS server slots. Flags live in flops; addresses, ports, client
// counts and missed-tick counts live in two RAMs with registered reads. One transaction
// is processed at a time. Register, disconnect and unknown operations go straight from
// acceptance to the result state; a heartbeat to a valid slot first writes back its
// cleared missed count. A tick reads every counter RAM slot, writing back each valid one,
// one slot per cycle, and then moves to the result state. A client request scans the
// counter RAM the same way, then, if it found a live server, updates the chosen slot and
// reads its endpoint. The sequencer returns to idle as its result moves to the output
// register; a stalled output holds it in the result state. A new transaction is taken
// as soon as the sequencer is idle, even while the previous result waits in the output
// register. The missed-limit register may be written at any time the block is idle;
// its port is always ready. No clearing pass follows reset.
module least_loaded_server_table_top #(
  parameter int unsigned SLOTS = llst_pkg::SlotsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [3:0]  slot_id_i,
  input  wire logic [31:0] server_address_i,
  input  wire logic [15:0] server_port_i,
  // Result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [3:0]       assigned_slot_o,
  output logic [31:0]      assigned_address_o,
  output logic [15:0]      assigned_port_o,
  output logic [15:0]      assigned_load_o,
  // Configuration channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_missed_limit_i
);

  logic           req_ready;
  llst_pkg::req_t req;
  logic           res_valid;
  logic           res_ready;
  llst_pkg::res_t res;

  logic [7:0]     missed_limit_q;
  logic           out_valid_q;
  llst_pkg::res_t out_q;

  // Missed-limit register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      missed_limit_q <= llst_pkg::MissedLimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      missed_limit_q <= cfg_missed_limit_i;
    end
  end

  // Request bundle
  assign req = '{operation: operation_i, slot_id: slot_id_i,
                 address: server_address_i, port: server_port_i};
  assign in_stall_o = !req_ready;

  llst_engine #(
    .SLOTS(SLOTS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (in_valid_i),
    .req_ready_o   (req_ready),
    .req_i         (req),
    .missed_limit_i(missed_limit_q),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // Output register: takes a new result whenever it is empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_q.status;
  assign assigned_slot_o    = out_q.slot;
  assign assigned_address_o = out_q.address;
  assign assigned_port_o    = out_q.port;
  assign assigned_load_o    = out_q.load;

endmodule

`default_nettype wire

### rtl/core/llst_engine.sv
// Sequencer and slot memories of the least-loaded server table.
// Holds valid/alive flags in flops and endpoints/counters in two RAMs; uses llst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module llst_engine #(
  parameter int unsigned SLOTS = llst_pkg::SlotsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire llst_pkg::req_t req_i,
  input  wire logic [7:0]    missed_limit_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output llst_pkg::res_t     res_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] Last = IdxW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HB,
    S_SCAN,
    S_CL_WR,
    S_CL_RD,
    S_OUT
  } state_e;

  state_e                 state_q;
  logic [IdxW-1:0]        idx_q;
  logic                   tick_q;
  logic                   found_q;
  logic [IdxW-1:0]        best_idx_q;
  llst_pkg::counters_t    best_q;
  logic [SLOTS-1:0]       valid_q;
  logic [SLOTS-1:0]       alive_q;
  llst_pkg::res_t         res_q;

  // Slot memories
  llst_pkg::endpoint_t    mem_a_q [SLOTS];
  llst_pkg::counters_t    mem_b_q [SLOTS];
  llst_pkg::endpoint_t    a_rdata_q;
  llst_pkg::counters_t    b_rdata_q;

  logic                   a_we;
  logic [IdxW-1:0]        a_waddr;
  llst_pkg::endpoint_t    a_wdata;
  logic [IdxW-1:0]        a_raddr;
  logic                   b_we;
  logic [IdxW-1:0]        b_waddr;
  llst_pkg::counters_t    b_wdata;
  logic [IdxW-1:0]        b_raddr;

  logic                   req_fire;
  logic                   in_table;
  logic [IdxW+3:0]        sid_ext;
  logic [IdxW-1:0]        sid_idx;
  logic                   eligible;
  logic                   better;
  logic [7:0]             tick_missed;
  logic [15:0]            inc_load;
  logic [IdxW+3:0]        best_ext;
  llst_pkg::status_e      idle_status;

  // Request decode and per-slot arithmetic
  always_comb begin
    req_fire    = req_valid_i && (state_q == S_IDLE);
    in_table    = 32'(req_i.slot_id) < SLOTS;
    sid_ext     = (IdxW + 4)'(req_i.slot_id);
    sid_idx     = sid_ext[IdxW-1:0];
    eligible    = valid_q[idx_q] && alive_q[idx_q];
    better      = eligible && (!found_q || (b_rdata_q.load < best_q.load));
    tick_missed = (b_rdata_q.missed == llst_pkg::MissedMax) ? llst_pkg::MissedMax
                                                             : b_rdata_q.missed + 8'd1;
    inc_load    = (best_q.load == llst_pkg::LoadMax) ? llst_pkg::LoadMax
                                                     : best_q.load + 16'd1;
    best_ext    = (IdxW + 4)'(best_idx_q);
    // Known operations start with an ok status; the rest are reported as unknown.
    unique case (req_i.operation)
      llst_pkg::OP_REGISTER, llst_pkg::OP_CLIENT, llst_pkg::OP_HEARTBEAT,
      llst_pkg::OP_DISCONNECT, llst_pkg::OP_TICK: idle_status = llst_pkg::ST_OK;
      default: idle_status = llst_pkg::ST_UNKNOWN;
    endcase
  end

  // Memory port control for each sequencer step
  always_comb begin
    a_we    = 1'b0;
    a_waddr = '0;
    a_wdata = '0;
    a_raddr = '0;
    b_we    = 1'b0;
    b_waddr = '0;
    b_wdata = '0;
    b_raddr = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire && in_table &&
            (req_i.operation == llst_pkg::OP_REGISTER)) begin
          a_we    = 1'b1;
          a_waddr = sid_idx;
          a_wdata = '{address: req_i.address, port: req_i.port};
          b_we    = 1'b1;
          b_waddr = sid_idx;
          b_wdata = '0;
        end
        if (req_i.operation == llst_pkg::OP_HEARTBEAT) begin
          b_raddr = sid_idx;
        end
      end
      S_HB: begin
        b_we    = 1'b1;
        b_waddr = idx_q;
        b_wdata = '{load: b_rdata_q.load, missed: 8'd0};
      end
      S_SCAN: begin
        if (idx_q != Last) begin
          b_raddr = IdxW'(idx_q + 1'b1);
        end
        if (tick_q && valid_q[idx_q]) begin
          b_we    = 1'b1;
          b_waddr = idx_q;
          b_wdata = '{load: b_rdata_q.load, missed: tick_missed};
        end
      end
      S_CL_WR: begin
        b_we    = 1'b1;
        b_waddr = best_idx_q;
        b_wdata = '{load: inc_load, missed: best_q.missed};
        a_raddr = best_idx_q;
      end
      S_CL_RD, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Synchronous memories with registered read data
  always_ff @(posedge clk_i) begin
    if (a_we) begin
      mem_a_q[a_waddr] <= a_wdata;
    end
    if (b_we) begin
      mem_b_q[b_waddr] <= b_wdata;
    end
    a_rdata_q <= mem_a_q[a_raddr];
    b_rdata_q <= mem_b_q[b_raddr];
  end

  // Sequencer, slot flags and the pending result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      tick_q     <= 1'b0;
      found_q    <= 1'b0;
      best_idx_q <= '0;
      best_q     <= '0;
      valid_q    <= '0;
      alive_q    <= '0;
      res_q      <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            res_q   <= '{status: idle_status, slot: '0, address: '0, port: '0, load: '0};
            idx_q   <= '0;
            found_q <= 1'b0;
            state_q <= S_OUT;
            unique case (req_i.operation)
              llst_pkg::OP_REGISTER: begin
                if (in_table) begin
                  valid_q[sid_idx] <= 1'b1;
                  alive_q[sid_idx] <= 1'b1;
                end
              end
              llst_pkg::OP_CLIENT: begin
                tick_q  <= 1'b0;
                state_q <= S_SCAN;
              end
              llst_pkg::OP_HEARTBEAT: begin
                if (in_table && valid_q[sid_idx]) begin
                  alive_q[sid_idx] <= 1'b1;
                  idx_q            <= sid_idx;
                  state_q          <= S_HB;
                end
              end
              llst_pkg::OP_DISCONNECT: begin
                if (in_table) begin
                  valid_q[sid_idx] <= 1'b0;
                  alive_q[sid_idx] <= 1'b0;
                end
              end
              llst_pkg::OP_TICK: begin
                tick_q  <= 1'b1;
                state_q <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_HB: begin
          state_q <= S_OUT;
        end
        S_SCAN: begin
          if (tick_q) begin
            if (valid_q[idx_q] && (tick_missed > missed_limit_i)) begin
              alive_q[idx_q] <= 1'b0;
            end
          end else if (better) begin
            found_q    <= 1'b1;
            best_idx_q <= idx_q;
            best_q     <= b_rdata_q;
          end
          if (idx_q == Last) begin
            if (tick_q) begin
              state_q <= S_OUT;
            end else if (found_q || better) begin
              state_q <= S_CL_WR;
            end else begin
              res_q.status <= llst_pkg::ST_NO_SERVER;
              state_q      <= S_OUT;
            end
          end else begin
            idx_q <= IdxW'(idx_q + 1'b1);
          end
        end
        S_CL_WR: begin
          res_q.status <= llst_pkg::ST_OK;
          res_q.slot   <= best_ext[3:0];
          res_q.load   <= inc_load;
          state_q      <= S_CL_RD;
        end
        S_CL_RD: begin
          res_q.address <= a_rdata_q.address;
          res_q.port    <= a_rdata_q.port;
          state_q       <= S_OUT;
        end
        S_OUT: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

  // Every accepted transaction takes the engine out of the idle state in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q != S_IDLE))
    else $error("engine returned to idle in the cycle after an accepted transaction");

  // A disconnect of a slot in the table leaves it empty and dead.
  a_disconnect_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && in_table && (req_i.operation == llst_pkg::OP_DISCONNECT))
    |=> (!valid_q[$past(sid_idx)] && !alive_q[$past(sid_idx)]))
    else $error("disconnected slot still marked valid or alive");

  // A slot is never alive without being valid.
  a_alive_implies_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((alive_q & ~valid_q) == '0))
    else $error("slot alive without a valid entry");

  // A result without a server, or of an unknown operation, carries no assignment.
  a_no_server_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_q.status != llst_pkg::ST_OK))
    |-> ((res_q.slot == '0) && (res_q.address == '0) && (res_q.port == '0) &&
         (res_q.load == '0)))
    else $error("non-ok result carries assignment fields");

  // The scan index stays inside the table.
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q <= Last))
    else $error("scan index beyond the last slot");

endmodule

`default_nettype wire

### tb/least_loaded_server_table_top_tb.sv
// Self-checking testbench for the least-loaded server table top level.
// Depends on llst_pkg and least_loaded_server_table_top, which needs llst_engine.
`timescale 1ns / 1ps

module least_loaded_server_table_top_tb;

  localparam int unsigned NumSlots = llst_pkg::SlotsDefault;
  localparam int HalfPeriod = 6;
  localparam int ResetCycles = 12;
  localparam int IdlePercent = 9;
  localparam int SettleCycles = NumSlots + 8;
  localparam int PhaseItems = 210;
  localparam int ResultHoldCycles = 400;
  localparam int SingleServerItems = 40;
  localparam int TickSaturationItems = 260;
  localparam longint CycleLimit = 400_000;
  localparam logic [2:0] OpUnknownFirst = 3'd5;
  localparam logic [2:0] OpUnknownMid = 3'd6;
  localparam logic [2:0] OpUnknownLast = 3'd7;
  localparam logic [7:0] MissedLimitNever = 8'hFF;

  // Tracks the server table and the results it must produce, oldest first.
  class server_table_scoreboard;
    bit             occupied [NumSlots];
    bit             alive    [NumSlots];
    logic [31:0]    address  [NumSlots];
    logic [15:0]    port     [NumSlots];
    logic [15:0]    load     [NumSlots];
    logic [7:0]     missed   [NumSlots];
    logic [7:0]     missed_limit;
    llst_pkg::res_t expected_q [$];
    int             error_count;

    function new();
      missed_limit = llst_pkg::MissedLimitReset;
      error_count = 0;
      for (int i = 0; i < NumSlots; i++) begin
        occupied[i] = 1'b0;
        alive[i] = 1'b0;
      end
    endfunction

    // Applies one accepted request to the table and queues the result it causes.
    function void note_request(llst_pkg::req_t req);
      llst_pkg::res_t res;
      int   best;
      bit   found;
      res = '0;
      best = 0;
      found = 1'b0;
      case (req.operation)
        llst_pkg::OP_REGISTER: begin
          occupied[req.slot_id] = 1'b1;
          alive[req.slot_id] = 1'b1;
          address[req.slot_id] = req.address;
          port[req.slot_id] = req.port;
          load[req.slot_id] = '0;
          missed[req.slot_id] = '0;
        end
        llst_pkg::OP_CLIENT: begin
          // Fewest clients wins; a strict compare keeps the lowest slot on ties.
          for (int i = 0; i < NumSlots; i++) begin
            if (occupied[i] && alive[i] && (!found || load[i] < load[best])) begin
              found = 1'b1;
              best = i;
            end
          end
          if (!found) begin
            res.status = llst_pkg::ST_NO_SERVER;
          end else begin
            if (load[best] != llst_pkg::LoadMax) load[best] = load[best] + 16'd1;
            res.status = llst_pkg::ST_OK;
            res.slot = best[3:0];
            res.address = address[best];
            res.port = port[best];
            res.load = load[best];
          end
        end
        llst_pkg::OP_HEARTBEAT: begin
          if (occupied[req.slot_id]) begin
            missed[req.slot_id] = '0;
            alive[req.slot_id] = 1'b1;
          end
        end
        llst_pkg::OP_DISCONNECT: begin
          occupied[req.slot_id] = 1'b0;
          alive[req.slot_id] = 1'b0;
        end
        llst_pkg::OP_TICK: begin
          for (int i = 0; i < NumSlots; i++) begin
            if (occupied[i]) begin
              if (missed[i] != llst_pkg::MissedMax) missed[i] = missed[i] + 8'd1;
              if (missed[i] > missed_limit) alive[i] = 1'b0;
            end
          end
        end
        default: begin
          res.status = llst_pkg::ST_UNKNOWN;
        end
      endcase
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        error_count++;
      end
    endfunction

    // Compares one accepted result with the oldest pending expectation.
    function void check_result(llst_pkg::res_t actual);
      llst_pkg::res_t want;
      if (expected_q.size() == 0) begin
        $error("result transaction arrived with no expectation pending");
        error_count++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", 32'(want.status), 32'(actual.status));
      compare_field("assigned_slot", 32'(want.slot), 32'(actual.slot));
      compare_field("assigned_address", want.address, actual.address);
      compare_field("assigned_port", 32'(want.port), 32'(actual.port));
      compare_field("assigned_load", 32'(want.load), 32'(actual.load));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        req_valid;
  logic        req_stall;
  logic [2:0]  req_operation;
  logic [3:0]  req_slot_id;
  logic [31:0] req_address;
  logic [15:0] req_port;
  logic        res_valid;
  logic        res_stall;
  logic [1:0]  res_status;
  logic [3:0]  res_slot;
  logic [31:0] res_address;
  logic [15:0] res_port;
  logic [15:0] res_load;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_missed_limit;

  server_table_scoreboard table_sb;
  bit     sender_idles;
  bit     receiver_idles;
  int     hold_request;
  int     hold_left;
  longint cycle_count;

  least_loaded_server_table_top dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (req_valid),
    .in_stall_o         (req_stall),
    .operation_i        (req_operation),
    .slot_id_i          (req_slot_id),
    .server_address_i   (req_address),
    .server_port_i      (req_port),
    .out_valid_o        (res_valid),
    .out_stall_i        (res_stall),
    .status_o           (res_status),
    .assigned_slot_o    (res_slot),
    .assigned_address_o (res_address),
    .assigned_port_o    (res_port),
    .assigned_load_o    (res_load),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_missed_limit_i (cfg_missed_limit)
  );

  always #HalfPeriod clk = ~clk;

  // The result side stalls at random, or for a long stretch when asked.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      res_stall = 1'b1;
      hold_left--;
    end else begin
      res_stall = receiver_idles && ($urandom_range(0, 99) < IdlePercent);
    end
  end

  // Every accepted result transaction is checked against the prediction.
  always @(posedge clk) begin
    llst_pkg::res_t actual;
    if (rst_n && res_valid && !res_stall) begin
      actual.status = llst_pkg::status_e'(res_status);
      actual.slot = res_slot;
      actual.address = res_address;
      actual.port = res_port;
      actual.load = res_load;
      table_sb.check_result(actual);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one request and holds it until the block takes it; returns at a falling edge.
  task automatic send_request(input logic [2:0] op, input logic [3:0] sid,
                              input logic [31:0] addr, input logic [15:0] prt);
    llst_pkg::req_t req;
    while (sender_idles && $urandom_range(0, 99) < IdlePercent) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req_operation = op;
    req_slot_id = sid;
    req_address = addr;
    req_port = prt;
    do @(posedge clk); while (req_stall);
    req.operation = op;
    req.slot_id = sid;
    req.address = addr;
    req.port = prt;
    table_sb.note_request(req);
    @(negedge clk);
  endtask

  // Mostly well-formed traffic of all five operations, with some unknown operations.
  task automatic send_random_request();
    int         pick;
    logic [2:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 15) op = llst_pkg::OP_REGISTER;
    else if (pick < 50) op = llst_pkg::OP_CLIENT;
    else if (pick < 70) op = llst_pkg::OP_HEARTBEAT;
    else if (pick < 77) op = llst_pkg::OP_DISCONNECT;
    else if (pick < 90) op = llst_pkg::OP_TICK;
    else op = 3'($urandom_range(OpUnknownFirst, OpUnknownLast));
    send_request(op, 4'($urandom_range(0, NumSlots - 1)), $urandom(),
                 16'($urandom_range(0, llst_pkg::LoadMax)));
  endtask

  // Stops offering and waits until every expected result has been taken.
  task automatic wait_drained();
    req_valid = 1'b0;
    while (table_sb.expected_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_missed_limit(input logic [7:0] limit);
    cfg_valid = 1'b1;
    cfg_missed_limit = limit;
    do @(posedge clk); while (!cfg_ready);
    table_sb.missed_limit = limit;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    logic [7:0] phase_limit [5];
    clk = 1'b0;
    rst_n = 1'b0;
    req_valid = 1'b0;
    req_operation = llst_pkg::OP_REGISTER;
    req_slot_id = '0;
    req_address = '0;
    req_port = '0;
    res_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_missed_limit = llst_pkg::MissedLimitReset;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    hold_request = 0;
    hold_left = 0;
    cycle_count = 0;
    table_sb = new();

    repeat (ResetCycles) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part: empty table, unknown operations, ties, replacement and expiry.
    send_request(llst_pkg::OP_CLIENT, 4'd0, 32'h0, 16'h0);
    send_request(OpUnknownFirst, 4'd3, 32'h1234_5678, 16'h00FF);
    send_request(OpUnknownMid, 4'd7, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(OpUnknownLast, 4'd15, 32'h0, 16'h0);
    send_request(llst_pkg::OP_HEARTBEAT, 4'd4, 32'h0, 16'h0);
    send_request(llst_pkg::OP_DISCONNECT, 4'd4, 32'h0, 16'h0);
    send_request(llst_pkg::OP_REGISTER, 4'd0, 32'h0, 16'h0);
    send_request(llst_pkg::OP_REGISTER, 4'd15, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(llst_pkg::OP_CLIENT, 4'd0, 32'h0, 16'h0);
    send_request(llst_pkg::OP_CLIENT, 4'd0, 32'h0, 16'h0);
    send_request(llst_pkg::OP_CLIENT, 4'd0, 32'h0, 16'h0);
    send_request(llst_pkg::OP_REGISTER, 4'd0, 32'hC0A8_0001, 16'd8080);
    send_request(llst_pkg::OP_CLIENT, 4'd0, 32'h0, 16'h0);
    repeat (3) send_request(llst_pkg::OP_TICK, 4'd0, 32'h0, 16'h0);
    send_request(llst_pkg::OP_CLIENT, 4'd0, 32'h0, 16'h0);
    send_request(llst_pkg::OP_HEARTBEAT, 4'd15, 32'h0, 16'h0);
    send_request(llst_pkg::OP_CLIENT, 4'd0, 32'h0, 16'h0);
    send_request(llst_pkg::OP_DISCONNECT, 4'd15, 32'h0, 16'h0);
    send_request(llst_pkg::OP_CLIENT, 4'd0, 32'h0, 16'h0);

    // Random phases, each under its own missed limit.
    phase_limit[0] = 8'($urandom_range(1, 8));
    phase_limit[1] = 8'd0;
    phase_limit[2] = 8'd254;
    phase_limit[3] = 8'($urandom_range(0, 254));
    phase_limit[4] = 8'd3;
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      write_missed_limit(phase_limit[p]);
      sender_idles = (p != 1);
      receiver_idles = (p != 1);
      // In the third phase results back up so that the block stalls its input.
      if (p == 2) hold_request = ResultHoldCycles;
      repeat (PhaseItems) send_random_request();
    end

    // Missed counts saturate; with the never-expire limit every live slot stays alive.
    wait_drained();
    write_missed_limit(MissedLimitNever);
    send_request(llst_pkg::OP_REGISTER, 4'd3, $urandom(),
                 16'($urandom_range(0, llst_pkg::LoadMax)));
    send_request(llst_pkg::OP_REGISTER, 4'd12, $urandom(),
                 16'($urandom_range(0, llst_pkg::LoadMax)));
    repeat (TickSaturationItems) send_request(llst_pkg::OP_TICK, 4'd0, 32'h0, 16'h0);
    repeat (2) send_request(llst_pkg::OP_CLIENT, 4'd0, 32'h0, 16'h0);
    wait_drained();
    write_missed_limit(8'd254);
    send_request(llst_pkg::OP_TICK, 4'd0, 32'h0, 16'h0);
    send_request(llst_pkg::OP_CLIENT, 4'd0, 32'h0, 16'h0);

    // A single live server takes every client, its count climbing each time.
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    for (int s = 0; s < NumSlots; s++) begin
      send_request(llst_pkg::OP_DISCONNECT, 4'(s), 32'h0, 16'h0);
    end
    send_request(llst_pkg::OP_REGISTER, 4'd9, $urandom(),
                 16'($urandom_range(0, llst_pkg::LoadMax)));
    repeat (SingleServerItems) begin
      send_request(llst_pkg::OP_CLIENT, 4'($urandom_range(0, NumSlots - 1)),
                   $urandom(), 16'($urandom_range(0, llst_pkg::LoadMax)));
    end

    wait_drained();
    if (table_sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/llst_pkg.sv
rtl/core/llst_engine.sv
rtl/core/least_loaded_server_table_top.sv
tb/least_loaded_server_table_top_tb.sv
